### src/vrtg_pkg.sv
// Shared types, constants and the tick-count decode for the variable-rate tick generator.
package vrtg_pkg;

  // Item kinds on the input channel
  localparam logic KIND_CRANK = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // Accumulator saturation limit and last phase before wrap
  localparam logic [3:0] ACC_MAX    = 4'd12;
  localparam logic [3:0] PHASE_LAST = 4'd11;

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [3:0]  acc_t;
  typedef logic [3:0]  phase_t;
  typedef logic [1:0]  tick_cnt_t;
  typedef logic [31:0] time_t;

  // One frame's worth of work for the back end
  typedef struct packed {
    tick_cnt_t ticks;
  } tick_job_t;

  // Divisibility tests on the phase (0..11)
  typedef struct packed {
    logic m2;
    logic m3;
    logic m4;
    logic m5;
    logic m7;
  } phase_mask_t;

  function automatic phase_mask_t phase_mask(input phase_t p);
    phase_mask_t m;
    m.m2 = ~p[0];
    m.m4 = (p[1:0] == 2'd0);
    unique case (p) inside
      4'd0:    begin m.m3 = 1'b1; m.m5 = 1'b1; m.m7 = 1'b1; end
      4'd3,
      4'd6,
      4'd9:    begin m.m3 = 1'b1; m.m5 = 1'b0; m.m7 = 1'b0; end
      4'd5,
      4'd10:   begin m.m3 = 1'b0; m.m5 = 1'b1; m.m7 = 1'b0; end
      4'd7:    begin m.m3 = 1'b0; m.m5 = 1'b0; m.m7 = 1'b1; end
      default: begin m.m3 = 1'b0; m.m5 = 1'b0; m.m7 = 1'b0; end
    endcase
    return m;
  endfunction

  // Ticks for a frame: rate level is acc/2, phase is already advanced
  function automatic tick_cnt_t tick_count(input acc_t acc, input phase_t p);
    phase_mask_t m;
    tick_cnt_t   n;
    m = phase_mask(p);
    unique case (acc[3:1]) inside
      3'd1:    n = m.m4 ? 2'd1 : 2'd0;
      3'd2:    n = (m.m2 | m.m5) ? 2'd1 : 2'd0;
      3'd3,
      3'd4:    n = 2'd1;
      3'd5:    n = (m.m2 | m.m3 | m.m5 | m.m7) ? 2'd2 : 2'd1;
      3'd6:    n = m.m2 ? 2'd3 : 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

### src/vrtg_front.sv
// Front end: accepts items, updates rate accumulator and phase, queues frame jobs.
module vrtg_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic signed [7:0]  in_crank_steps,
  output logic               q_push,
  output vrtg_pkg::tick_job_t q_job,
  input  logic               q_full
);
  import vrtg_pkg::*;

  acc_t   acc_r, acc_nxt;
  phase_t phase_r, phase_nxt;
  logic   accept;
  logic signed [9:0] sum;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Saturating accumulate and phase advance
  always_comb begin
    sum       = $signed({6'd0, acc_r}) + $signed({{2{in_crank_steps[7]}}, in_crank_steps});
    acc_nxt   = acc_r;
    phase_nxt = phase_r;
    if (accept && in_kind == KIND_CRANK) begin
      if (sum < 10'sd0)
        acc_nxt = 4'd0;
      else if (sum > $signed({6'd0, ACC_MAX}))
        acc_nxt = ACC_MAX;
      else
        acc_nxt = sum[3:0];
    end else if (accept && in_kind == KIND_FRAME) begin
      phase_nxt = (phase_r == PHASE_LAST) ? 4'd0 : phase_r + 4'd1;
    end
  end

  // Classify the frame: only frames with ticks reach the back end
  assign q_job.ticks = tick_count(acc_r, phase_nxt);
  assign q_push      = accept && (in_kind == KIND_FRAME) && (q_job.ticks != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      phase_r <= '0;
    end else begin
      acc_r   <= acc_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

### src/vrtg_queue.sv
// Short FIFO of frame jobs between front and back end.
module vrtg_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  vrtg_pkg::tick_job_t push_job,
  output logic                full,
  input  logic                pop,
  output vrtg_pkg::tick_job_t pop_job,
  output logic                empty
);
  import vrtg_pkg::*;

  tick_job_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push)
      mem_r[wr_ptr_r] <= push_job;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### src/vrtg_back.sv
// Back end: expands queued jobs into ticks, owns the time counter and output register.
module vrtg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  vrtg_pkg::tick_job_t q_job,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_time_value,
  output logic                out_start_flag,
  output logic                out_end_flag
);
  import vrtg_pkg::*;

  logic      busy_r;
  tick_cnt_t total_r, idx_r;
  time_t     time_r;
  logic      out_valid_r;
  time_t     out_time_r;
  logic      out_start_r, out_end_r;
  logic      load, emit, last;

  // Output register can take a new tick when empty or being drained
  assign load  = !out_valid_r || !out_stall;
  assign emit  = load && busy_r;
  assign last  = (idx_r + 2'd1) == total_r;
  assign q_pop = !q_empty && (!busy_r || (emit && last));

  // Job sequencer and time counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      total_r <= '0;
      idx_r   <= '0;
      time_r  <= '0;
    end else begin
      if (emit)
        time_r <= time_r + 32'd1;
      if (q_pop) begin
        busy_r  <= 1'b1;
        total_r <= q_job.ticks;
        idx_r   <= '0;
      end else if (emit && last) begin
        busy_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (load)
      out_valid_r <= busy_r;
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_time_r  <= time_r + 32'd1;
      out_start_r <= (idx_r == 2'd0);
      out_end_r   <= last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_time_value = out_time_r;
  assign out_start_flag = out_start_r;
  assign out_end_flag   = out_end_r;

endmodule

### src/variable_rate_tick_generator_core.sv
// Top level of the variable-rate tick generator: front end, job queue, back end.
//
// A crank transaction yields no result; it adjusts the saturating rate accumulator (0..12).
// A frame transaction advances the phase (modulo 12) and, if it calls for any ticks, places a
// job of 1 to 3 ticks in a two-entry queue. The back end drains that queue at one result per
// cycle while the output is not stalled, through an output register, so a frame with n ticks
// yields n results and the result channel sets the sustained rate; cranks and tickless
// frames place no job. Each result carries the incremented 32-bit time counter; the first
// result of a frame has start_flag set and the last has end_flag set. The input is stalled
// only while the job queue is full.
module variable_rate_tick_generator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic signed [7:0] in_crank_steps,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_time_value,
  output logic              out_start_flag,
  output logic              out_end_flag
);
  import vrtg_pkg::*;

  logic      q_push, q_full, q_pop, q_empty;
  tick_job_t push_job, pop_job;

  vrtg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_crank_steps (in_crank_steps),
    .q_push         (q_push),
    .q_job          (push_job),
    .q_full         (q_full)
  );

  vrtg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  vrtg_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_job          (pop_job),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_time_value (out_time_value),
    .out_start_flag (out_start_flag),
    .out_end_flag   (out_end_flag)
  );

  // Queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  // A frame's ticks follow each other without gaps
  a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && !out_end_flag) |=> out_valid)
    else $error("frame ended without end flag");

endmodule
